/* sv/histogram_bin_accumulator_macros.svh */
// Assertion macros used by the histogram datapath module.
`ifndef HISTOGRAM_BIN_ACCUMULATOR_MACROS_SVH
`define HISTOGRAM_BIN_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define HBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HBA_ASSERT_IMP(lbl, ante, cons, msg)
`define HBA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/hba_pkg.sv */
`timescale 1ns / 1ps

package hba_pkg;

    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_PEAK   = 2'd2;
    localparam logic [1:0] FN_DUMP   = 2'd3;

    localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] CFG_BIN_SCALE  = 2'd2;
    localparam logic [1:0] CFG_BIN_WIDTH  = 2'd3;

    typedef struct packed {
        logic load_in;
        logic ctr_clr;
        logic ctr_inc;
        logic rmw_rd;
        logic wr_bin;
        logic scan_cmp;
        logic sel_best;
        logic out_load;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic ctr_last;
        logic out_free;
    } t_sts;

endpackage

/* sv/hba_ram.sv */
`timescale 1ns / 1ps

module hba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* sv/hba_ctrl.sv */
`timescale 1ns / 1ps

module hba_ctrl
    import hba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RD,
        S_WR,
        S_PRD,
        S_PCMP,
        S_PMUL,
        S_POUT,
        S_DRD,
        S_DOUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.ctr_clr = 1'b1;
                    unique case (i_func) inside
                        FN_ADD, FN_REMOVE: n_state = S_MUL;
                        FN_PEAK:           n_state = S_PRD;
                        FN_DUMP:           n_state = S_DRD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rmw_rd = 1'b1;
                n_state      = i_sts.in_range ? S_WR : S_IDLE;
            end
            S_WR: begin
                o_cmd.wr_bin = 1'b1;
                n_state      = S_IDLE;
            end
            S_PRD: begin
                n_state = S_PCMP;
            end
            S_PCMP: begin
                o_cmd.scan_cmp = 1'b1;
                if (i_sts.ctr_last) begin
                    n_state = S_PMUL;
                end else begin
                    o_cmd.ctr_inc = 1'b1;
                    n_state       = S_PRD;
                end
            end
            S_PMUL: begin
                o_cmd.sel_best = 1'b1;
                n_state        = S_POUT;
            end
            S_POUT: begin
                o_cmd.sel_best = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DRD: begin
                n_state = S_DOUT;
            end
            S_DOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = i_sts.ctr_last;
                    if (i_sts.ctr_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ctr_inc = 1'b1;
                        n_state       = S_DRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // no transfer while reset is held
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);

endmodule

/* sv/hba_dp.sv */
`timescale 1ns / 1ps
`include "histogram_bin_accumulator_macros.svh"

module hba_dp
    import hba_pkg::*;
#(
    parameter int BINS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_sample,
    input  logic               i_out_stall,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [5:0]         o_bin_index,
    output logic [31:0]        o_bin_count,
    output logic signed [31:0] o_bin_center,
    output logic               o_last
);

    localparam int IW = $clog2(BINS);
    localparam logic [IW-1:0] LAST_BIN = IW'(BINS - 1);

    logic signed [31:0] r_low;
    logic signed [31:0] r_high;
    logic [31:0]        r_scale;
    logic [30:0]        r_width;

    logic [1:0]         r_func;
    logic signed [31:0] r_sample;
    logic               r_in_range;
    logic [63:0]        r_prod;

    logic [BINS-1:0]    r_vld;
    logic               r_rd_vld;
    logic [IW-1:0]      r_ctr;
    logic [31:0]        r_best;
    logic [IW-1:0]      r_best_idx;
    logic [36:0]        r_cprod;

    logic               r_out_valid;
    logic [5:0]         r_out_idx;
    logic [31:0]        r_out_cnt;
    logic signed [31:0] r_out_ctr;
    logic               r_out_last;

    logic [31:0]        w_diff;
    logic [IW-1:0]      w_bin;
    logic [IW-1:0]      w_raddr;
    logic [31:0]        w_ram_q;
    logic [31:0]        w_cnt;
    logic [31:0]        w_wdata;
    logic [IW-1:0]      w_sel_idx;
    logic signed [39:0] w_csum;
    logic signed [31:0] w_center;

    assign w_diff  = r_sample - r_low;
    assign w_bin   = (r_prod[63:32] >= 32'(BINS)) ? LAST_BIN : r_prod[32+IW-1:32];
    assign w_raddr = i_cmd.rmw_rd ? w_bin : r_ctr;
    assign w_cnt   = r_rd_vld ? w_ram_q : 32'd0;

    always_comb begin
        if (r_func == FN_ADD) begin
            w_wdata = (w_cnt == 32'hFFFF_FFFF) ? w_cnt : w_cnt + 32'd1;
        end else begin
            w_wdata = (w_cnt == 32'd0) ? w_cnt : w_cnt - 32'd1;
        end
    end

    assign w_sel_idx = i_cmd.sel_best ? r_best_idx : r_ctr;

    assign w_csum = $signed({{8{r_low[31]}}, r_low})
                  + $signed({10'd0, r_width[30:1]})
                  + $signed({3'd0, r_cprod});

    always_comb begin
        if (w_csum > 40'sd2147483647) begin
            w_center = 32'sh7FFF_FFFF;
        end else if (w_csum < -40'sd2147483648) begin
            w_center = 32'sh8000_0000;
        end else begin
            w_center = w_csum[31:0];
        end
    end

    hba_ram #(
        .WIDTH(32),
        .DEPTH(BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_bin),
        .i_waddr (w_bin),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= 32'sd0;
            r_high      <= 32'sd4194304;
            r_scale     <= 32'd65536;
            r_width     <= 31'd65536;
            r_vld       <= '0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RANGE_LOW:  r_low   <= i_cfg_data;
                    CFG_RANGE_HIGH: r_high  <= i_cfg_data;
                    CFG_BIN_SCALE:  r_scale <= i_cfg_data;
                    CFG_BIN_WIDTH:  r_width <= i_cfg_data[30:0];
                    default:        r_low   <= r_low;
                endcase
            end
            if (i_cmd.wr_bin) begin
                r_vld[w_bin] <= 1'b1;
            end
            if (i_cmd.ctr_clr) begin
                r_ctr <= '0;
            end else if (i_cmd.ctr_inc) begin
                r_ctr <= r_ctr + IW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func   <= i_func;
            r_sample <= i_sample;
        end
        r_in_range <= (r_sample >= r_low) && (r_sample <= r_high);
        r_prod     <= {32'd0, w_diff} * {32'd0, r_scale};
        r_rd_vld   <= r_vld[w_raddr];
        r_cprod    <= {6'd0, r_width} * {31'd0, 6'(w_sel_idx)};
        if (i_cmd.scan_cmp && (r_ctr == '0 || w_cnt > r_best)) begin
            r_best     <= w_cnt;
            r_best_idx <= r_ctr;
        end
        if (i_cmd.out_load) begin
            r_out_idx  <= 6'(w_sel_idx);
            r_out_cnt  <= i_cmd.sel_best ? r_best : w_cnt;
            r_out_ctr  <= w_center;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.in_range = r_in_range;
    assign o_sts.ctr_last = (r_ctr == LAST_BIN);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_bin_index  = r_out_idx;
    assign o_bin_count  = r_out_cnt;
    assign o_bin_center = r_out_ctr;
    assign o_last       = r_out_last;

    // a bin is only written for an in-range sample
    `HBA_ASSERT_IMP(a_wr_in_range, i_cmd.wr_bin, r_in_range, "bin write for out-of-range sample")
    // a pending result is never overwritten
    `HBA_ASSERT_IMP(a_no_overwrite, i_cmd.out_load, !r_out_valid || !i_out_stall,
                    "output register overwritten while stalled")
    `HBA_ASSERT_NXT(a_vld_set, i_cmd.wr_bin, r_vld != '0, "bin valid not set after write")

endmodule

/* sv/histogram_bin_accumulator.sv */
`timescale 1ns / 1ps

// Fixed-range histogram of signed Q16.16 samples with BINS saturating 32-bit
// counters, cleared at reset by per-bin valid flags (no clearing pass). An add
// or remove registers the sample, forms the 32x32 bin position product,
// reads the bin memory and writes it back, with the input stalled until it
// is done; a sample outside the range skips the write. A peak query scans
// the bin memory with a registered read, then a compare, for each bin, then
// forms the centre of the best bin and gives one result with last set. A
// dump reads each bin in turn and gives BINS results, holding while the
// output is stalled, last set on the final one. The input is stalled while
// reset is held. Configuration writes take effect on the next edge and
// must only be made while the block is idle.
module histogram_bin_accumulator
    import hba_pkg::*;
#(
    parameter int BINS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [5:0]         o_bin_index,
    output logic [31:0]        o_bin_count,
    output logic signed [31:0] o_bin_center,
    output logic               o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    hba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hba_dp #(
        .BINS(BINS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_sample     (i_sample),
        .i_out_stall  (i_out_stall),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_bin_index  (o_bin_index),
        .o_bin_count  (o_bin_count),
        .o_bin_center (o_bin_center),
        .o_last       (o_last)
    );

endmodule
